[sv/sha512_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 hash core package
// Transfer types, round constants and the initial hash for the SHA-512 core.
// ----------------------------------------------------------------------------
package sha512_pkg;

  // Geometry of one compression.
  localparam int unsigned NumRounds    = 80;
  localparam int unsigned BlockWords   = 16;
  localparam int unsigned DigestWords  = 8;
  localparam int unsigned WordBytes    = 8;

  // Input transfer: one message word.
  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
  } in_t;

  // Output transfer: one digest word.
  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } out_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StFinal,
    StOut
  } sha_state_e;

  // Progress through the padding of the final block(s).
  typedef enum logic [2:0] {
    PhNone,
    PhData,
    PhMark,
    PhZero,
    PhLenLo,
    PhDone
  } pad_phase_e;

  // Padding marker for a message that ends on a word boundary.
  localparam logic [63:0] PadMarker = 64'h8000_0000_0000_0000;

  localparam logic [63:0] InitHash [DigestWords] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] RoundK [NumRounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

endpackage

[sv/sha512_hash_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-512 hash core
// Iterative SHA-512: one compression round per cycle over a rolling schedule.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) takes one 64-bit
//   big-endian message word per transfer. Every word but the last carries
//   eight bytes; the last one carries 0 to 8 bytes and closes the message.
//   The sixteenth word of a block starts a compression (80 rounds plus the
//   hash update), during which in_stall_o is high and no further message
//   word is accepted until the hash update of that block is complete.
//   After the last word the core appends padding one word per cycle, runs
//   one or two more compressions and then offers the eight digest words
//   H0..H7 on the output channel (out_valid_o / out_stall_i / out_data_o),
//   one per transfer, digest_last set on H7. While out_stall_i is high the
//   current digest word is held. After H7 the core is back at the initial
//   hash and accepts the next message.
//   Reset (rst_ni low) clears the sequencer, counters and hash at once; the
//   core accepts a word in the first cycle after reset.
// ----------------------------------------------------------------------------
module sha512_hash_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sha512_pkg::in_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sha512_pkg::out_t  out_data_o
);

  localparam logic [3:0] LastPos   = 4'(sha512_pkg::BlockWords - 1);
  localparam logic [3:0] LenHiPos  = 4'(sha512_pkg::BlockWords - 2);
  localparam logic [6:0] LastRound = 7'(sha512_pkg::NumRounds - 1);
  localparam logic [2:0] LastIdx   = 3'(sha512_pkg::DigestWords - 1);
  localparam logic [3:0] FullWord  = 4'(sha512_pkg::WordBytes);

  // SHA-512 mixing functions.
  function automatic logic [63:0] big0(input logic [63:0] v);
    big0 = {v[27:0], v[63:28]} ^ {v[33:0], v[63:34]} ^ {v[38:0], v[63:39]};
  endfunction

  function automatic logic [63:0] big1(input logic [63:0] v);
    big1 = {v[13:0], v[63:14]} ^ {v[17:0], v[63:18]} ^ {v[40:0], v[63:41]};
  endfunction

  function automatic logic [63:0] small0(input logic [63:0] v);
    small0 = {v[0], v[63:1]} ^ {v[7:0], v[63:8]} ^ {7'd0, v[63:7]};
  endfunction

  function automatic logic [63:0] small1(input logic [63:0] v);
    small1 = {v[18:0], v[63:19]} ^ {v[60:0], v[63:61]} ^ {6'd0, v[63:6]};
  endfunction

  // Keep the first n bytes, put the 0x80 marker right after them.
  function automatic logic [63:0] pad_word(input logic [63:0] data, input logic [2:0] n);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) begin
        res[63 - 8*i -: 8] = data[63 - 8*i -: 8];
      end else if (3'(i) == n) begin
        res[63 - 8*i -: 8] = 8'h80;
      end
    end
    return res;
  endfunction

  // Control state.
  sha512_pkg::sha_state_e state_q, state_d;
  sha512_pkg::pad_phase_e phase_q, phase_d;
  logic [3:0]  pos_q;
  logic [6:0]  round_q;
  logic [2:0]  out_idx_q;
  logic [63:0] msg_bytes_q;
  logic [63:0] hash_q [sha512_pkg::DigestWords];

  // Datapath state.
  logic [63:0] sched_q [sha512_pkg::BlockWords];
  logic [63:0] work_q  [sha512_pkg::DigestWords];
  logic [63:0] last_data_q;
  logic [3:0]  last_n_q;

  logic        in_xfer;
  logic        out_xfer;
  logic        push_en;
  logic [63:0] push_val;
  logic [3:0]  in_n_sat;
  logic [63:0] wt;
  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] ch;
  logic [63:0] maj;

  assign in_stall_o  = (state_q != sha512_pkg::StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == sha512_pkg::StOut);
  assign out_xfer    = out_valid_o && !out_stall_i;

  assign in_n_sat = (in_data_i.byte_count > FullWord) ? FullWord : in_data_i.byte_count;

  assign out_data_o.digest_word = hash_q[out_idx_q];
  assign out_data_o.word_index  = out_idx_q;
  assign out_data_o.digest_last = (out_idx_q == LastIdx);

  // Schedule word and round arithmetic of the shared round unit.
  always_comb begin
    if (round_q[6:4] == 3'd0) begin
      wt = sched_q[0];
    end else begin
      wt = sched_q[0] + small0(sched_q[1]) + sched_q[9] + small1(sched_q[14]);
    end
    ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
    maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
    t1  = work_q[7] + big1(work_q[4]) + ch + sha512_pkg::RoundK[round_q] + wt;
    t2  = big0(work_q[0]) + maj;
  end

  // Sequencer: next state and block word pushes.
  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    push_en  = 1'b0;
    push_val = '0;
    case (state_q)
      sha512_pkg::StIdle: begin
        if (in_xfer) begin
          if (!in_data_i.last) begin
            push_en  = 1'b1;
            push_val = in_data_i.data_word;
            if (pos_q == LastPos) begin
              state_d = sha512_pkg::StRound;
            end
          end else begin
            state_d = sha512_pkg::StPad;
            phase_d = sha512_pkg::PhData;
          end
        end
      end
      sha512_pkg::StPad: begin
        push_en = 1'b1;
        case (phase_q)
          sha512_pkg::PhData: begin
            if (last_n_q[3]) begin
              push_val = last_data_q;
              phase_d  = sha512_pkg::PhMark;
            end else begin
              push_val = pad_word(last_data_q, last_n_q[2:0]);
              phase_d  = sha512_pkg::PhZero;
            end
          end
          sha512_pkg::PhMark: begin
            push_val = sha512_pkg::PadMarker;
            phase_d  = sha512_pkg::PhZero;
          end
          sha512_pkg::PhZero: begin
            // Zeros until the length words fit at the end of a block.
            if (pos_q == LenHiPos) begin
              push_val = {61'd0, msg_bytes_q[63:61]};
              phase_d  = sha512_pkg::PhLenLo;
            end else begin
              push_val = '0;
            end
          end
          sha512_pkg::PhLenLo: begin
            push_val = {msg_bytes_q[60:0], 3'd0};
            phase_d  = sha512_pkg::PhDone;
          end
          default: begin
            push_val = '0;
          end
        endcase
        if (pos_q == LastPos) begin
          state_d = sha512_pkg::StRound;
        end
      end
      sha512_pkg::StRound: begin
        if (round_q == LastRound) begin
          state_d = sha512_pkg::StFinal;
        end
      end
      sha512_pkg::StFinal: begin
        case (phase_q)
          sha512_pkg::PhNone: state_d = sha512_pkg::StIdle;
          sha512_pkg::PhDone: state_d = sha512_pkg::StOut;
          default:            state_d = sha512_pkg::StPad;
        endcase
      end
      sha512_pkg::StOut: begin
        if (out_xfer && (out_idx_q == LastIdx)) begin
          state_d = sha512_pkg::StIdle;
          phase_d = sha512_pkg::PhNone;
        end
      end
      default: begin
        state_d = sha512_pkg::StIdle;
        phase_d = sha512_pkg::PhNone;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha512_pkg::StIdle;
      phase_q <= sha512_pkg::PhNone;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  // Counters, byte count and chaining hash.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      round_q     <= '0;
      out_idx_q   <= '0;
      msg_bytes_q <= '0;
      for (int i = 0; i < sha512_pkg::DigestWords; i++) begin
        hash_q[i] <= sha512_pkg::InitHash[i];
      end
    end else begin
      if (push_en) begin
        pos_q <= pos_q + 4'd1;
      end
      if (in_xfer) begin
        if (in_data_i.last) begin
          msg_bytes_q <= msg_bytes_q + {60'd0, in_n_sat};
        end else begin
          msg_bytes_q <= msg_bytes_q + {60'd0, FullWord};
        end
      end
      if (state_q == sha512_pkg::StRound) begin
        round_q <= (round_q == LastRound) ? 7'd0 : round_q + 7'd1;
      end
      // Fold the working variables into the chaining hash.
      if (state_q == sha512_pkg::StFinal) begin
        for (int i = 0; i < sha512_pkg::DigestWords; i++) begin
          hash_q[i] <= hash_q[i] + work_q[i];
        end
      end
      // Digest readout; the last transfer restarts the hash.
      if (out_xfer) begin
        out_idx_q <= out_idx_q + 3'd1;
        if (out_idx_q == LastIdx) begin
          msg_bytes_q <= '0;
          pos_q       <= '0;
          for (int i = 0; i < sha512_pkg::DigestWords; i++) begin
            hash_q[i] <= sha512_pkg::InitHash[i];
          end
        end
      end
    end
  end

  // Rolling schedule, working variables and the captured last word.
  always_ff @(posedge clk_i) begin
    if (in_xfer && in_data_i.last) begin
      last_data_q <= in_data_i.data_word;
      last_n_q    <= in_n_sat;
    end
    // The schedule shifts on each pushed word and on each round.
    if (push_en || (state_q == sha512_pkg::StRound)) begin
      for (int i = 0; i < sha512_pkg::BlockWords - 1; i++) begin
        sched_q[i] <= sched_q[i + 1];
      end
      sched_q[sha512_pkg::BlockWords - 1] <= push_en ? push_val : wt;
    end
    if (push_en && (pos_q == LastPos)) begin
      for (int i = 0; i < sha512_pkg::DigestWords; i++) begin
        work_q[i] <= hash_q[i];
      end
    end else if (state_q == sha512_pkg::StRound) begin
      work_q[7] <= work_q[6];
      work_q[6] <= work_q[5];
      work_q[5] <= work_q[4];
      work_q[4] <= work_q[3] + t1;
      work_q[3] <= work_q[2];
      work_q[2] <= work_q[1];
      work_q[1] <= work_q[0];
      work_q[0] <= t1 + t2;
    end
  end

endmodule
